FILE: hdl/fcat_pkg.sv
`timescale 1ns / 1ps

package fcat_pkg;

   // Largest channel count the decode and queue entry are sized for
   localparam int MAX_CHANNELS = 8;
   // Interrupt lines brought out on the result
   localparam int IRQ_LINES = 4;
   // Words per channel register block (0x14 bytes)
   localparam int STRIDE_WORDS = 5;
   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Item kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // Register offsets inside a channel block, in words
   localparam logic [2:0] SUB_LOAD   = 3'd0;
   localparam logic [2:0] SUB_COUNT  = 3'd1;
   localparam logic [2:0] SUB_CTRL   = 3'd2;
   localparam logic [2:0] SUB_EOI    = 3'd3;
   localparam logic [2:0] SUB_STATUS = 3'd4;

   // Global word addresses
   localparam logic [9:0] WADDR_INT_STATUS = 10'h028;  // byte 0xa0
   localparam logic [9:0] WADDR_EOI        = 10'h029;  // byte 0xa4
   localparam logic [9:0] WADDR_RAW_STATUS = 10'h02a;  // byte 0xa8
   localparam logic [9:0] WADDR_VERSION    = 10'h02b;  // byte 0xac
   localparam logic [9:0] WADDR_LOAD2      = 10'h02c;  // byte 0xb0
   localparam logic [9:0] WADDR_PROT       = 10'h034;  // byte 0xd0

   // Control word bits and masks
   localparam int CTRL_ENABLE_BIT = 0;
   localparam int CTRL_MODE_BIT   = 1;
   localparam int CTRL_MASK_BIT   = 2;
   localparam logic [3:0] CTRL_VALID = 4'hf;
   localparam logic [2:0] PROT_VALID = 3'h7;

   // Reset values
   localparam logic [31:0] COUNT_RESET = 32'h8000_0000;
   localparam logic [2:0]  PROT_RESET  = 3'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  word_address;
      logic [31:0] write_data;
   } req_item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [3:0]  irq_lines;
      logic        access_error;
   } rsp_item_type;

   // Classified operation carried from front to back
   typedef enum logic [4:0] {
      OP_NOP,
      OP_ERR,
      OP_TICK,
      OP_RD_LOAD,
      OP_RD_COUNT,
      OP_RD_CTRL,
      OP_RD_EOI,
      OP_RD_MSTAT,
      OP_RD_INT_STATUS,
      OP_RD_GEOI,
      OP_RD_RAW,
      OP_RD_VERSION,
      OP_RD_LOAD2,
      OP_RD_PROT,
      OP_WR_LOAD,
      OP_WR_CTRL,
      OP_WR_LOAD2,
      OP_WR_PROT
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [MAX_CHANNELS-1:0] chan_sel;
      logic [31:0]             write_data;
   } queue_entry_type;

endpackage

FILE: hdl/fcat_front.sv
`timescale 1ns / 1ps

module fcat_front #(
   parameter int CHANNELS = 4
) (
   input  fcat_pkg::req_item_type    req_payload,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      q_full,
   output logic                      push_valid,
   output fcat_pkg::queue_entry_type push_entry
);

   logic [fcat_pkg::MAX_CHANNELS-1:0] chan_hit;
   logic [fcat_pkg::MAX_CHANNELS-1:0] load2_hit;
   logic [fcat_pkg::MAX_CHANNELS-1:0] prot_hit;
   logic [9:0]                        base;
   logic [9:0]                        diff;
   logic [2:0]                        sub;
   logic [9:0]                        wa;

   // Stall only on a full queue
   assign req_stall  = q_full;
   assign push_valid = req_valid && !q_full;
   assign wa         = req_payload.word_address;

   // Find the channel block and the per-channel global slots
   always_comb begin
      chan_hit  = '0;
      load2_hit = '0;
      prot_hit  = '0;
      sub       = '0;
      base      = '0;
      diff      = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         base = 10'(c * fcat_pkg::STRIDE_WORDS);
         if (wa >= base && wa < base + 10'(fcat_pkg::STRIDE_WORDS)) begin
            chan_hit[c] = 1'b1;
            diff        = wa - base;
            sub         = diff[2:0];
         end
         if (wa == fcat_pkg::WADDR_LOAD2 + 10'(c)) begin
            load2_hit[c] = 1'b1;
         end
         if (wa == fcat_pkg::WADDR_PROT + 10'(c)) begin
            prot_hit[c] = 1'b1;
         end
      end
   end

   // Classify the item into one operation
   always_comb begin
      push_entry            = '0;
      push_entry.op         = fcat_pkg::OP_NOP;
      push_entry.write_data = req_payload.write_data;
      case (req_payload.kind)
         fcat_pkg::KIND_READ: begin
            if (|chan_hit) begin
               push_entry.chan_sel = chan_hit;
               case (sub)
                  fcat_pkg::SUB_LOAD:  push_entry.op = fcat_pkg::OP_RD_LOAD;
                  fcat_pkg::SUB_COUNT: push_entry.op = fcat_pkg::OP_RD_COUNT;
                  fcat_pkg::SUB_CTRL:  push_entry.op = fcat_pkg::OP_RD_CTRL;
                  fcat_pkg::SUB_EOI:   push_entry.op = fcat_pkg::OP_RD_EOI;
                  default:             push_entry.op = fcat_pkg::OP_RD_MSTAT;
               endcase
            end else if (wa == fcat_pkg::WADDR_INT_STATUS) begin
               push_entry.op = fcat_pkg::OP_RD_INT_STATUS;
            end else if (wa == fcat_pkg::WADDR_EOI) begin
               push_entry.op = fcat_pkg::OP_RD_GEOI;
            end else if (wa == fcat_pkg::WADDR_RAW_STATUS) begin
               push_entry.op = fcat_pkg::OP_RD_RAW;
            end else if (wa == fcat_pkg::WADDR_VERSION) begin
               push_entry.op = fcat_pkg::OP_RD_VERSION;
            end else if (|load2_hit) begin
               push_entry.op       = fcat_pkg::OP_RD_LOAD2;
               push_entry.chan_sel = load2_hit;
            end else if (|prot_hit) begin
               push_entry.op       = fcat_pkg::OP_RD_PROT;
               push_entry.chan_sel = prot_hit;
            end else begin
               push_entry.op = fcat_pkg::OP_ERR;
            end
         end
         fcat_pkg::KIND_WRITE: begin
            if (|chan_hit) begin
               push_entry.chan_sel = chan_hit;
               case (sub)
                  fcat_pkg::SUB_LOAD: push_entry.op = fcat_pkg::OP_WR_LOAD;
                  fcat_pkg::SUB_CTRL: push_entry.op = fcat_pkg::OP_WR_CTRL;
                  default:            push_entry.op = fcat_pkg::OP_ERR;
               endcase
            end else if (|load2_hit) begin
               push_entry.op       = fcat_pkg::OP_WR_LOAD2;
               push_entry.chan_sel = load2_hit;
            end else if (|prot_hit) begin
               push_entry.op       = fcat_pkg::OP_WR_PROT;
               push_entry.chan_sel = prot_hit;
            end else begin
               push_entry.op = fcat_pkg::OP_ERR;
            end
         end
         fcat_pkg::KIND_TICK: begin
            push_entry.op = fcat_pkg::OP_TICK;
         end
         default: begin
            push_entry.op = fcat_pkg::OP_NOP;
         end
      endcase
   end

endmodule

FILE: hdl/fcat_queue.sv
`timescale 1ns / 1ps

module fcat_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  fcat_pkg::queue_entry_type push_entry,
   output logic                      q_full,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output fcat_pkg::queue_entry_type pop_entry
);

   localparam int PTR_W = $clog2(fcat_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(fcat_pkg::QUEUE_DEPTH + 1);

   fcat_pkg::queue_entry_type entries_ff [fcat_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign q_full    = (count_ff == CNT_W'(fcat_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];
   assign push      = push_valid && !q_full;
   assign pop       = pop_ready && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(fcat_pkg::QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("queue pop did not drain an entry");

endmodule

FILE: hdl/fcat_back.sv
`timescale 1ns / 1ps

module fcat_back #(
   parameter int CHANNELS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_ready,
   input  fcat_pkg::queue_entry_type q_entry,
   input  logic                      csr_write,
   input  logic [31:0]               csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output fcat_pkg::rsp_item_type    rsp_payload
);

   // Channel state
   logic [31:0]         load_ff   [CHANNELS];
   logic [31:0]         load_in   [CHANNELS];
   logic [3:0]          ctrl_ff   [CHANNELS];
   logic [3:0]          ctrl_in   [CHANNELS];
   logic [31:0]         count_ff  [CHANNELS];
   logic [31:0]         count_in  [CHANNELS];
   logic [31:0]         load2_ff  [CHANNELS];
   logic [31:0]         load2_in  [CHANNELS];
   logic [2:0]          prot_ff   [CHANNELS];
   logic [2:0]          prot_in   [CHANNELS];
   logic [CHANNELS-1:0] raw_ff, raw_in;
   logic [31:0]         version_ff;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   fcat_pkg::rsp_item_type rsp_payload_ff, rsp_payload_in;

   logic                             take;
   logic [CHANNELS-1:0]              sel;
   logic [CHANNELS-1:0]              mstat_cur;
   logic [fcat_pkg::IRQ_LINES-1:0]   irq_next;
   logic [fcat_pkg::IRQ_LINES-1:0]   irq_cur;
   logic [31:0]                      rd_load, rd_count, rd_load2;
   logic [3:0]                       rd_ctrl;
   logic [2:0]                       rd_prot;

   assign sel         = q_entry.chan_sel[CHANNELS-1:0];
   assign q_ready     = !rsp_valid_ff || !rsp_stall;
   assign take        = q_valid && q_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Per-channel masked status before the item
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         mstat_cur[c] = raw_ff[c] & ~ctrl_ff[c][fcat_pkg::CTRL_MASK_BIT];
      end
   end

   // Interrupt lines before and after the item
   for (genvar g = 0; g < fcat_pkg::IRQ_LINES; g++) begin : g_irq
      if (g < CHANNELS) begin : g_on
         assign irq_next[g] = raw_in[g] & ~ctrl_in[g][fcat_pkg::CTRL_MASK_BIT];
         assign irq_cur[g]  = mstat_cur[g];
      end else begin : g_off
         assign irq_next[g] = 1'b0;
         assign irq_cur[g]  = 1'b0;
      end
   end

   // Select the addressed channel's registers
   always_comb begin
      rd_load  = '0;
      rd_count = '0;
      rd_load2 = '0;
      rd_ctrl  = '0;
      rd_prot  = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (sel[c]) begin
            rd_load  = rd_load | load_ff[c];
            rd_count = rd_count | count_ff[c];
            rd_load2 = rd_load2 | load2_ff[c];
            rd_ctrl  = rd_ctrl | ctrl_ff[c];
            rd_prot  = rd_prot | prot_ff[c];
         end
      end
   end

   // Apply the operation to every channel lane
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         load_in[c]  = load_ff[c];
         ctrl_in[c]  = ctrl_ff[c];
         count_in[c] = count_ff[c];
         load2_in[c] = load2_ff[c];
         prot_in[c]  = prot_ff[c];
         raw_in[c]   = raw_ff[c];
         if (take) begin
            case (q_entry.op)
               fcat_pkg::OP_TICK: begin
                  if (ctrl_ff[c][fcat_pkg::CTRL_ENABLE_BIT]) begin
                     if (count_ff[c] != '0) begin
                        count_in[c] = count_ff[c] - 32'd1;
                        if (count_ff[c] == 32'd1) begin
                           raw_in[c] = 1'b1;
                        end
                     end else if (ctrl_ff[c][fcat_pkg::CTRL_MODE_BIT]) begin
                        count_in[c] = load_ff[c];
                     end else begin
                        count_in[c] = '1;
                     end
                  end
               end
               fcat_pkg::OP_RD_EOI: begin
                  if (sel[c]) begin
                     raw_in[c] = 1'b0;
                  end
               end
               fcat_pkg::OP_RD_GEOI: begin
                  raw_in[c] = 1'b0;
               end
               fcat_pkg::OP_WR_LOAD: begin
                  if (sel[c]) begin
                     load_in[c]  = q_entry.write_data;
                     count_in[c] = q_entry.write_data;
                  end
               end
               fcat_pkg::OP_WR_CTRL: begin
                  if (sel[c]) begin
                     ctrl_in[c] = q_entry.write_data[3:0] & fcat_pkg::CTRL_VALID;
                  end
               end
               fcat_pkg::OP_WR_LOAD2: begin
                  if (sel[c]) begin
                     load2_in[c] = q_entry.write_data;
                  end
               end
               fcat_pkg::OP_WR_PROT: begin
                  if (sel[c]) begin
                     prot_in[c] = q_entry.write_data[2:0] & fcat_pkg::PROT_VALID;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Build the result
   always_comb begin
      rsp_payload_in              = '0;
      rsp_payload_in.irq_lines    = irq_next;
      rsp_payload_in.access_error = (q_entry.op == fcat_pkg::OP_ERR);
      case (q_entry.op)
         fcat_pkg::OP_RD_LOAD:       rsp_payload_in.read_data = rd_load;
         fcat_pkg::OP_RD_COUNT:      rsp_payload_in.read_data = rd_count;
         fcat_pkg::OP_RD_CTRL:       rsp_payload_in.read_data = 32'(rd_ctrl);
         fcat_pkg::OP_RD_MSTAT:      rsp_payload_in.read_data = 32'(|(mstat_cur & sel));
         fcat_pkg::OP_RD_INT_STATUS: rsp_payload_in.read_data = 32'(mstat_cur);
         fcat_pkg::OP_RD_RAW:        rsp_payload_in.read_data = 32'(raw_ff);
         fcat_pkg::OP_RD_VERSION:    rsp_payload_in.read_data = version_ff;
         fcat_pkg::OP_RD_LOAD2:      rsp_payload_in.read_data = rd_load2;
         fcat_pkg::OP_RD_PROT:       rsp_payload_in.read_data = 32'(rd_prot);
         default:                    rsp_payload_in.read_data = '0;
      endcase
   end

   // Hold the result until it is taken
   assign rsp_valid_in = take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         raw_ff       <= '0;
         version_ff   <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            load_ff[c]  <= '0;
            ctrl_ff[c]  <= '0;
            count_ff[c] <= fcat_pkg::COUNT_RESET;
            load2_ff[c] <= '0;
            prot_ff[c]  <= fcat_pkg::PROT_RESET;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         raw_ff       <= raw_in;
         if (csr_write) begin
            version_ff <= csr_data;
         end
         for (int c = 0; c < CHANNELS; c++) begin
            load_ff[c]  <= load_in[c];
            ctrl_ff[c]  <= ctrl_in[c];
            count_ff[c] <= count_in[c];
            load2_ff[c] <= load2_in[c];
            prot_ff[c]  <= prot_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   a_geoi_clears: assert property (@(posedge clock) disable iff (reset)
      (take && q_entry.op == fcat_pkg::OP_RD_GEOI) |=> (raw_ff == '0))
      else $error("global EOI left a raw interrupt set");

   a_irq_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.irq_lines == irq_cur))
      else $error("pending irq lines differ from channel state");

endmodule

FILE: hdl/four_channel_apb_countdown_timer.sv
`timescale 1ns / 1ps

// Multi-channel down-counting interval timer, register view.
// Request channel (req_valid / req_stall / req_payload): a register read, a
// register write, or one timer tick. Each request gives exactly one result on
// the response channel (rsp_valid / rsp_stall / rsp_payload) carrying read
// data, the per-channel interrupt lines after the request, and an access error.
// The version register is written through csr_valid / csr_data; csr_ready is
// always high and writes are expected only while no request is in flight.
// A request accepted from the request channel is held in a queue entry, and the
// back end then writes its result into the result register. Throughput is one
// request per cycle while rsp_stall is low: the front decoder pushes into a
// two-entry queue and the back end applies one entry per cycle to all channel counters in parallel.
// When rsp_stall is high the result register holds; the queue keeps taking
// requests until its two entries fill, then req_stall rises.
// Synchronous reset empties the queue, clears the result valid flag and returns all
// channel registers to their reset values (count 0x80000000, protection 2).
module four_channel_apb_countdown_timer #(
   parameter int CHANNELS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fcat_pkg::req_item_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fcat_pkg::rsp_item_type rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [31:0]            csr_data
);

   logic                      q_full;
   logic                      push_valid;
   fcat_pkg::queue_entry_type push_entry;
   logic                      pop_valid;
   logic                      pop_ready;
   fcat_pkg::queue_entry_type pop_entry;

   assign csr_ready = 1'b1;

   fcat_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .req_payload (req_payload),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   fcat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   fcat_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (pop_valid),
      .q_ready     (pop_ready),
      .q_entry     (pop_entry),
      .csr_write   (csr_valid && csr_ready),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
